>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL of the meta-event parser.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

>>> hdl/mmep_pkg.sv
// Package for the meta-event parser: codes, parse phases and the classified byte type.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package mmep_pkg;

    // Longest variable-length quantity for the payload length, in bytes.
    localparam int LENGTH_MAX_BYTES = 4;
    localparam int LCNT_W           = $clog2(LENGTH_MAX_BYTES + 1);

    localparam int LEN_W   = 28;
    localparam int VAL_W   = 40;
    localparam int TDATA_W = 120;

    // Lead byte of every meta-event and the sequencer-specific type.
    localparam logic [7:0] LEAD_BYTE     = 8'hFF;
    localparam logic [7:0] TYPE_SEQ_SPEC = 8'h7F;

    // Result status codes.
    localparam logic [1:0] ST_BUSY    = 2'd0;
    localparam logic [1:0] ST_PAYLOAD = 2'd1;
    localparam logic [1:0] ST_DONE    = 2'd2;
    localparam logic [1:0] ST_ERROR   = 2'd3;

    // Error codes.
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_LEAD      = 3'd1;
    localparam logic [2:0] ERR_BAD_LEN   = 3'd2;
    localparam logic [2:0] ERR_SEQ_ZERO  = 3'd3;
    localparam logic [2:0] ERR_EARLY_END = 3'd4;
    localparam logic [2:0] ERR_LONG_LEN  = 3'd5;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TYPE,
        PH_LEN,
        PH_FIXED,
        PH_PASS,
        PH_SKIP
    } phase_t;

    // One stream byte together with the properties the parser needs.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
        logic       is_lead;
        logic       cont;
        logic       fixed_ok;
        logic [2:0] fixed_len;
        logic       is_pass;
        logic       is_seq;
    } byte_class_t;

endpackage

>>> hdl/midi_meta_event_parser_top.sv
// Top level of the meta-event parser: front end, byte queue and parser back end.
// Depends on mmep_pkg, mmep_front, mmep_queue, mmep_back and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Parses standard MIDI file meta-events (0xFF, type, variable-length length,
// payload) and returns exactly one result transfer for every input transfer.
// The block sustains one byte per clock cycle while the output side is ready;
// the back end parser state register sets it, taking one queued byte per cycle.
// When the queue is empty and the output side is ready, the result of a byte
// is held in a queue entry and then in the output register, from which it is
// taken at the next rising edge. A two-entry queue separates the classifying
// front end from the parser, so bytes can enter the queue while a result waits.
// Text and sequencer-specific bytes come out with status payload; fixed-size
// events come out with their payload packed big-endian in decoded_value on
// completion. After any error the parser waits for 0xFF.
module midi_meta_event_parser_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,  // [7:0] data_byte
    input  logic                          s_tuser,  // [0] stream_end
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [2:0] error_code, [10:3] meta_type, [38:11] data_length,
    // [46:39] payload_byte, [74:47] payload_index, [114:75] decoded_value, rest zero
    output logic [mmep_pkg::TDATA_W-1:0]  m_tdata,
    output logic [1:0]                    m_tuser   // [1:0] status
);
    import mmep_pkg::*;

    byte_class_t push_item;
    byte_class_t pop_item;
    logic        push;
    logic        pop;
    logic        queue_full;
    logic        queue_empty;

    mmep_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    mmep_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (queue_empty)
    );

    mmep_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .pop_item    (pop_item),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // An error code is reported only together with the error status.
    `ASSERT_PROP(a_err_only_on_error, clk, rst_n,
        (m_tvalid && (m_tuser != ST_ERROR)) |-> (m_tdata[2:0] == ERR_NONE))
    // Payload byte and index are zero unless a payload byte is passed.
    `ASSERT_PROP(a_payload_fields, clk, rst_n,
        (m_tvalid && (m_tuser != ST_PAYLOAD)) |->
            ((m_tdata[46:39] == 8'd0) && (m_tdata[74:47] == '0)))
    // A packed value appears only on event completion.
    `ASSERT_NEVER(a_value_only_done, clk, rst_n,
        m_tvalid && (m_tdata[114:75] != '0) && (m_tuser != ST_DONE))
    // A passed payload byte always lies inside the decoded length.
    `ASSERT_PROP(a_index_in_range, clk, rst_n,
        (m_tvalid && (m_tuser == ST_PAYLOAD)) |-> (m_tdata[74:47] < m_tdata[38:11]))

endmodule

>>> hdl/mmep_front.sv
// Front end of the meta-event parser: accepts stream bytes and classifies them.
// Depends on mmep_pkg; feeds mmep_queue.
`timescale 1ns / 1ps

module mmep_front (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] data_byte
    input  logic                 s_tuser,   // [0] stream_end
    input  logic                 queue_full,
    output logic                 push,
    output mmep_pkg::byte_class_t push_item
);
    import mmep_pkg::*;

    // A transfer is taken whenever the queue has room.
    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    // Classify the byte both as a plain stream byte and as a possible type code.
    always_comb
    begin
        push_item            = '0;
        push_item.data_byte  = s_tdata;
        push_item.stream_end = s_tuser;
        push_item.is_lead    = (s_tdata == LEAD_BYTE);
        push_item.cont       = s_tdata[7];
        push_item.is_seq     = (s_tdata == TYPE_SEQ_SPEC);
        push_item.is_pass    = ((s_tdata >= 8'h01) && (s_tdata <= 8'h07))
                               || (s_tdata == TYPE_SEQ_SPEC);
        unique case (s_tdata)
            8'h00:
            begin
                push_item.fixed_ok  = 1'b1;
                push_item.fixed_len = 3'd2;
            end
            8'h20:
            begin
                push_item.fixed_ok  = 1'b1;
                push_item.fixed_len = 3'd1;
            end
            8'h2F:
            begin
                push_item.fixed_ok  = 1'b1;
                push_item.fixed_len = 3'd0;
            end
            8'h51:
            begin
                push_item.fixed_ok  = 1'b1;
                push_item.fixed_len = 3'd3;
            end
            8'h54:
            begin
                push_item.fixed_ok  = 1'b1;
                push_item.fixed_len = 3'd5;
            end
            8'h58:
            begin
                push_item.fixed_ok  = 1'b1;
                push_item.fixed_len = 3'd4;
            end
            8'h59:
            begin
                push_item.fixed_ok  = 1'b1;
                push_item.fixed_len = 3'd2;
            end
            default:
            begin
                push_item.fixed_ok  = 1'b0;
                push_item.fixed_len = 3'd0;
            end
        endcase
    end

endmodule

>>> hdl/mmep_queue.sv
// Two-entry queue of classified bytes between the front end and the parser.
// Depends on mmep_pkg.
`timescale 1ns / 1ps

module mmep_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  mmep_pkg::byte_class_t push_item,
    output logic                  full,
    input  logic                  pop,
    output mmep_pkg::byte_class_t pop_item,
    output logic                  empty
);
    import mmep_pkg::*;

    byte_class_t entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_item = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage carries no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> hdl/mmep_back.sv
// Back end of the meta-event parser: event state machine and registered result.
// Depends on mmep_pkg; drains mmep_queue one byte per cycle unless output stalls.
`timescale 1ns / 1ps

module mmep_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          queue_empty,
    input  mmep_pkg::byte_class_t         pop_item,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mmep_pkg::TDATA_W-1:0]  m_tdata,
    output logic [1:0]                    m_tuser
);
    import mmep_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [7:0]        type_reg, type_next;
    logic              fixed_ok_reg, fixed_ok_next;
    logic [2:0]        fixed_len_reg, fixed_len_next;
    logic              pass_reg, pass_next;
    logic              seq_reg, seq_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LCNT_W-1:0] lcnt_reg, lcnt_next;
    logic [LEN_W-1:0]  pcnt_reg, pcnt_next;
    logic [VAL_W-1:0]  val_reg, val_next;

    logic              out_valid_reg, out_valid_next;
    logic [1:0]        out_status_reg;
    logic [TDATA_W-1:0] out_data_reg;

    // Per-byte arithmetic shared by the phases.
    logic              len_ovf;
    logic [LEN_W-1:0]  len_shift;
    logic [LCNT_W-1:0] lcnt_inc;
    logic [LEN_W-1:0]  pcnt_inc;
    logic              pcnt_done;
    logic [VAL_W-1:0]  val_shift;
    logic              len_fixed_bad;
    logic              lcnt_limit;

    logic [1:0]        status;
    logic [2:0]        err;
    logic [7:0]        pbyte;
    logic [LEN_W-1:0]  pidx;
    logic [VAL_W-1:0]  dval;

    // A byte leaves the queue when the output register is free or draining.
    assign pop = !queue_empty && (!out_valid_reg || m_tready);

    assign len_ovf       = |len_reg[LEN_W-1:21];
    assign len_shift     = {len_reg[20:0], pop_item.data_byte[6:0]};
    assign lcnt_inc      = lcnt_reg + LCNT_W'(1);
    assign lcnt_limit    = (lcnt_inc >= LCNT_W'(LENGTH_MAX_BYTES));
    assign pcnt_inc      = pcnt_reg + LEN_W'(1);
    assign pcnt_done     = (pcnt_inc >= len_reg);
    assign val_shift     = {val_reg[VAL_W-9:0], pop_item.data_byte};
    assign len_fixed_bad = (len_shift != LEN_W'(fixed_len_reg));

    // Next parse phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (pop)
        begin
            if (pop_item.stream_end)
            begin
                phase_next = PH_IDLE;
            end
            else
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        if (pop_item.is_lead)
                        begin
                            phase_next = PH_TYPE;
                        end
                    end
                    PH_TYPE:
                    begin
                        phase_next = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        priority if (len_ovf)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else if (pop_item.cont)
                        begin
                            if (lcnt_limit)
                            begin
                                phase_next = PH_IDLE;
                            end
                        end
                        else if (fixed_ok_reg)
                        begin
                            if (len_fixed_bad || (fixed_len_reg == 3'd0))
                            begin
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                phase_next = PH_FIXED;
                            end
                        end
                        else if (len_shift == '0)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = pass_reg ? PH_PASS : PH_SKIP;
                        end
                    end
                    PH_FIXED, PH_PASS, PH_SKIP:
                    begin
                        if (pcnt_done)
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Event registers and the result of the current byte.
    always_comb
    begin
        type_next      = type_reg;
        fixed_ok_next  = fixed_ok_reg;
        fixed_len_next = fixed_len_reg;
        pass_next      = pass_reg;
        seq_next       = seq_reg;
        len_next       = len_reg;
        lcnt_next      = lcnt_reg;
        pcnt_next      = pcnt_reg;
        val_next       = val_reg;
        status         = ST_BUSY;
        err            = ERR_NONE;
        pbyte          = 8'd0;
        pidx           = '0;
        dval           = '0;
        if (pop_item.stream_end)
        begin
            if (phase_reg != PH_IDLE)
            begin
                status = ST_ERROR;
                err    = ERR_EARLY_END;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (!pop_item.is_lead)
                    begin
                        status = ST_ERROR;
                        err    = ERR_LEAD;
                    end
                end
                PH_TYPE:
                begin
                    type_next      = pop_item.data_byte;
                    fixed_ok_next  = pop_item.fixed_ok;
                    fixed_len_next = pop_item.fixed_len;
                    pass_next      = pop_item.is_pass;
                    seq_next       = pop_item.is_seq;
                    len_next       = '0;
                    lcnt_next      = '0;
                    pcnt_next      = '0;
                    val_next       = '0;
                end
                PH_LEN:
                begin
                    if (len_ovf)
                    begin
                        status = ST_ERROR;
                        err    = ERR_LONG_LEN;
                    end
                    else
                    begin
                        len_next  = len_shift;
                        lcnt_next = lcnt_inc;
                        priority if (pop_item.cont)
                        begin
                            if (lcnt_limit)
                            begin
                                status = ST_ERROR;
                                err    = ERR_LONG_LEN;
                            end
                        end
                        else if (fixed_ok_reg)
                        begin
                            if (len_fixed_bad)
                            begin
                                status = ST_ERROR;
                                err    = ERR_BAD_LEN;
                            end
                            else if (fixed_len_reg == 3'd0)
                            begin
                                status = ST_DONE;
                            end
                        end
                        else if (len_shift == '0)
                        begin
                            // Zero-length sequencer-specific data is an error,
                            // any other empty payload completes at once.
                            if (seq_reg)
                            begin
                                status = ST_ERROR;
                                err    = ERR_SEQ_ZERO;
                            end
                            else
                            begin
                                status = ST_DONE;
                            end
                        end
                    end
                end
                PH_FIXED:
                begin
                    val_next  = val_shift;
                    pcnt_next = pcnt_inc;
                    if (pcnt_done)
                    begin
                        status = ST_DONE;
                        dval   = val_shift;
                    end
                end
                PH_PASS:
                begin
                    status    = ST_PAYLOAD;
                    pbyte     = pop_item.data_byte;
                    pidx      = pcnt_reg;
                    pcnt_next = pcnt_inc;
                end
                PH_SKIP:
                begin
                    pcnt_next = pcnt_inc;
                    if (pcnt_done)
                    begin
                        status = ST_DONE;
                    end
                end
                default:
                begin
                    status = ST_BUSY;
                end
            endcase
        end
    end

    // Output register stays full until the downstream side takes it.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            type_reg      <= '0;
            fixed_ok_reg  <= 1'b0;
            fixed_len_reg <= '0;
            pass_reg      <= 1'b0;
            seq_reg       <= 1'b0;
            len_reg       <= '0;
            lcnt_reg      <= '0;
            pcnt_reg      <= '0;
            val_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                phase_reg     <= phase_next;
                type_reg      <= type_next;
                fixed_ok_reg  <= fixed_ok_next;
                fixed_len_reg <= fixed_len_next;
                pass_reg      <= pass_next;
                seq_reg       <= seq_next;
                len_reg       <= len_next;
                lcnt_reg      <= lcnt_next;
                pcnt_reg      <= pcnt_next;
                val_reg       <= val_next;
            end
        end
    end

    // Result payload is loaded with each byte and needs no reset.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_status_reg <= status;
            out_data_reg   <= {5'd0, dval, pidx, pbyte, len_next, type_next, err};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> bench/midi_meta_event_parser_top_tb.sv
// Self-checking testbench for the MIDI meta-event parser top level.
// Depends on mmep_pkg and midi_meta_event_parser_top; reads no files.
`timescale 1ns / 1ps

module midi_meta_event_parser_top_tb;

    import mmep_pkg::*;

    // Meta-event type codes used by the stimulus and the expected-result model.
    localparam logic [7:0] TYPE_SEQ_NUM      = 8'h00;
    localparam logic [7:0] TYPE_TEXT_FIRST   = 8'h01;
    localparam logic [7:0] TYPE_TEXT_LAST    = 8'h07;
    localparam logic [7:0] TYPE_CHAN_PREFIX  = 8'h20;
    localparam logic [7:0] TYPE_END_OF_TRACK = 8'h2F;
    localparam logic [7:0] TYPE_TEMPO        = 8'h51;
    localparam logic [7:0] TYPE_SMPTE        = 8'h54;
    localparam logic [7:0] TYPE_TIME_SIG     = 8'h58;
    localparam logic [7:0] TYPE_KEY_SIG      = 8'h59;
    localparam logic [7:0] TYPE_UNKNOWN      = 8'h60;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 10;
    localparam int RANDOM_BYTES   = 2000;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int FILL_RANDOM    = -1;

    // One parser result, field by field.
    typedef struct {
        logic [1:0]  status;
        logic [2:0]  error_code;
        logic [7:0]  meta_type;
        logic [27:0] data_length;
        logic [7:0]  payload_byte;
        logic [27:0] payload_index;
        logic [39:0] decoded_value;
    } meta_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TDATA_W-1:0]   m_tdata;
    logic [1:0]           m_tuser;

    // Expected parser results, oldest first.
    meta_result_t         pending_results[$];

    // Shadow copy of the parser state.
    phase_t               shadow_phase;
    logic [7:0]           shadow_type;
    logic [27:0]          shadow_length;
    int                   shadow_length_bytes;
    logic [27:0]          shadow_payload_count;
    logic [39:0]          shadow_value;

    int                   mismatch_count;
    int                   bytes_sent;
    int                   cycle_count;
    int                   stall_left;
    bit                   send_gaps_on;
    bit                   out_stalls_on;

    midi_meta_event_parser_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_HALF) clk = ~clk;

    // Run guard: a hung handshake ends the run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Required payload length of a fixed-size type, or -1 for other types.
    function automatic int fixed_size(input logic [7:0] t);
        case (t)
            TYPE_SEQ_NUM:      return 2;
            TYPE_CHAN_PREFIX:  return 1;
            TYPE_END_OF_TRACK: return 0;
            TYPE_TEMPO:        return 3;
            TYPE_SMPTE:        return 5;
            TYPE_TIME_SIG:     return 4;
            TYPE_KEY_SIG:      return 2;
            default:           return -1;
        endcase
    endfunction

    // Text and sequencer-specific types pass their payload through.
    function automatic bit is_passed_type(input logic [7:0] t);
        return (t >= TYPE_TEXT_FIRST && t <= TYPE_TEXT_LAST) || t == TYPE_SEQ_SPEC;
    endfunction

    // Advances the shadow parser by one accepted byte and queues the result it gives.
    function automatic void predict_parse(input logic [7:0] b, input logic stream_end);
        meta_result_t r;
        int           need;
        r = '{default: '0};
        if (stream_end)
        begin
            if (shadow_phase != PH_IDLE)
            begin
                r.status     = ST_ERROR;
                r.error_code = ERR_EARLY_END;
                shadow_phase = PH_IDLE;
            end
        end
        else
        begin
            case (shadow_phase)
                PH_IDLE:
                begin
                    if (b == LEAD_BYTE)
                        shadow_phase = PH_TYPE;
                    else
                    begin
                        r.status     = ST_ERROR;
                        r.error_code = ERR_LEAD;
                    end
                end
                PH_TYPE:
                begin
                    shadow_type          = b;
                    shadow_length        = '0;
                    shadow_length_bytes  = 0;
                    shadow_payload_count = '0;
                    shadow_value         = '0;
                    shadow_phase         = PH_LEN;
                end
                PH_LEN:
                begin
                    // A length that already fills more than 21 bits cannot take 7 more.
                    if (shadow_length[27:21] != '0)
                    begin
                        r.status     = ST_ERROR;
                        r.error_code = ERR_LONG_LEN;
                        shadow_phase = PH_IDLE;
                    end
                    else
                    begin
                        shadow_length       = {shadow_length[20:0], b[6:0]};
                        shadow_length_bytes = shadow_length_bytes + 1;
                        if (b[7])
                        begin
                            if (shadow_length_bytes >= LENGTH_MAX_BYTES)
                            begin
                                r.status     = ST_ERROR;
                                r.error_code = ERR_LONG_LEN;
                                shadow_phase = PH_IDLE;
                            end
                        end
                        else
                        begin
                            need = fixed_size(shadow_type);
                            if (need >= 0)
                            begin
                                if (int'(shadow_length) != need)
                                begin
                                    r.status     = ST_ERROR;
                                    r.error_code = ERR_BAD_LEN;
                                    shadow_phase = PH_IDLE;
                                end
                                else if (need == 0)
                                begin
                                    r.status     = ST_DONE;
                                    shadow_phase = PH_IDLE;
                                end
                                else
                                    shadow_phase = PH_FIXED;
                            end
                            else if (shadow_type == TYPE_SEQ_SPEC && shadow_length == '0)
                            begin
                                r.status     = ST_ERROR;
                                r.error_code = ERR_SEQ_ZERO;
                                shadow_phase = PH_IDLE;
                            end
                            else if (shadow_length == '0)
                            begin
                                r.status     = ST_DONE;
                                shadow_phase = PH_IDLE;
                            end
                            else if (is_passed_type(shadow_type))
                                shadow_phase = PH_PASS;
                            else
                                shadow_phase = PH_SKIP;
                        end
                    end
                end
                PH_FIXED:
                begin
                    shadow_value         = {shadow_value[31:0], b};
                    shadow_payload_count = shadow_payload_count + 1'b1;
                    if (shadow_payload_count >= shadow_length)
                    begin
                        r.status        = ST_DONE;
                        r.decoded_value = shadow_value;
                        shadow_phase    = PH_IDLE;
                    end
                end
                PH_PASS:
                begin
                    r.status             = ST_PAYLOAD;
                    r.payload_byte       = b;
                    r.payload_index      = shadow_payload_count;
                    shadow_payload_count = shadow_payload_count + 1'b1;
                    if (shadow_payload_count >= shadow_length)
                        shadow_phase = PH_IDLE;
                end
                PH_SKIP:
                begin
                    shadow_payload_count = shadow_payload_count + 1'b1;
                    if (shadow_payload_count >= shadow_length)
                    begin
                        r.status     = ST_DONE;
                        shadow_phase = PH_IDLE;
                    end
                end
                default:
                    shadow_phase = PH_IDLE;
            endcase
        end
        r.meta_type   = shadow_type;
        r.data_length = shadow_length;
        pending_results.insert(pending_results.size(), r);
    endfunction

    // Sends one byte transfer; called and returning just after a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic stream_end);
        int gap;
        gap = send_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom_range(0, 255));
            s_tuser  <= 1'($urandom_range(0, 1));
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= stream_end;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_parse(b, stream_end);
        bytes_sent = bytes_sent + 1;
        @(negedge clk);
    endtask

    // Sends lead, type and length (padded with leading zero groups), then body payload bytes.
    task automatic send_event(input logic [7:0] t, input int unsigned len, input int pad,
                              input int unsigned body, input int fill);
        int groups;
        int i;
        groups = 1;
        while (groups < LENGTH_MAX_BYTES && (len >> (7 * groups)) != 0)
            groups = groups + 1;
        groups = groups + pad;
        if (groups > LENGTH_MAX_BYTES)
            groups = LENGTH_MAX_BYTES;
        send_byte(LEAD_BYTE, 1'b0);
        send_byte(t, 1'b0);
        for (i = groups - 1; i >= 0; i--)
            send_byte({(i != 0), 7'(len >> (7 * i))}, 1'b0);
        for (i = 0; i < int'(body); i++)
            send_byte((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill), 1'b0);
    endtask

    // A length field whose every byte keeps the continuation bit set.
    task automatic send_overlong_length(input logic [7:0] t);
        int i;
        send_byte(LEAD_BYTE, 1'b0);
        send_byte(t, 1'b0);
        for (i = 0; i < LENGTH_MAX_BYTES; i++)
            send_byte(8'h80 | 8'($urandom_range(0, 127)), 1'b0);
    endtask

    // Payload lengths: mostly short, some that need a two-byte length field.
    function automatic int unsigned pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 6);
        else if (r < 95)
            return $urandom_range(7, 40);
        else
            return $urandom_range(120, 300);
    endfunction

    // Output side: ready drops for random stretches while stalls are enabled.
    always @(negedge clk)
    begin
        if (!out_stalls_on)
            m_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left <= pick_gap();
        end
    end

    task automatic check_field(input string name, input logic [39:0] want_v,
                               input logic [39:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            mismatch_count = mismatch_count + 1;
        end
    endtask

    // Each result transfer is compared with the oldest expected result.
    always @(posedge clk)
    begin : result_check
        meta_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no result expected");
                mismatch_count = mismatch_count + 1;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", want.status, m_tuser);
                check_field("error_code", want.error_code, m_tdata[2:0]);
                check_field("meta_type", want.meta_type, m_tdata[10:3]);
                check_field("data_length", want.data_length, m_tdata[38:11]);
                check_field("payload_byte", want.payload_byte, m_tdata[46:39]);
                check_field("payload_index", want.payload_index, m_tdata[74:47]);
                check_field("decoded_value", want.decoded_value, m_tdata[114:75]);
            end
        end
    end

    // Wrong lead bytes and a stream end while idle.
    task automatic test_idle_handling();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h5A, 1'b1);
    endtask

    // Largest tempo value and the empty end-of-track event.
    task automatic test_fixed_events();
        send_event(TYPE_TEMPO, 3, 0, 3, 255);
        send_event(TYPE_END_OF_TRACK, 0, 0, 0, FILL_RANDOM);
    endtask

    // Zero-length text completes; zero-length sequencer data is an error.
    task automatic test_zero_length_payloads();
        send_event(TYPE_TEXT_LAST, 0, 0, 0, FILL_RANDOM);
        send_event(TYPE_SEQ_SPEC, 0, 0, 0, FILL_RANDOM);
    endtask

    // Zero-length unknown type behind a four-byte length, then a length that never ends.
    task automatic test_length_field();
        send_event(TYPE_UNKNOWN, 0, 3, 0, FILL_RANDOM);
        send_overlong_length(TYPE_SMPTE);
    endtask

    // The stream ends in the middle of a text payload.
    task automatic test_early_end();
        send_event(TYPE_TEXT_FIRST, 2, 0, 1, 0);
        send_byte(8'hFF, 1'b1);
    endtask

    // One random event: mostly well formed, the rest broken or noise.
    task automatic send_random_event();
        int          kind;
        int          need;
        int unsigned len;
        int unsigned cut;
        logic [7:0]  t;
        kind = $urandom_range(0, 99);
        if (kind < 30)
        begin
            // Fixed-size event with the right length.
            case ($urandom_range(0, 6))
                0:       t = TYPE_SEQ_NUM;
                1:       t = TYPE_CHAN_PREFIX;
                2:       t = TYPE_END_OF_TRACK;
                3:       t = TYPE_TEMPO;
                4:       t = TYPE_SMPTE;
                5:       t = TYPE_TIME_SIG;
                default: t = TYPE_KEY_SIG;
            endcase
            need = fixed_size(t);
            send_event(t, need, $urandom_range(0, 1) ? 0 : $urandom_range(1, 3), need,
                       FILL_RANDOM);
        end
        else if (kind < 80)
        begin
            // Text, sequencer-specific or unknown type with a matching payload.
            if (kind < 55)
                t = 8'($urandom_range(TYPE_TEXT_FIRST, TYPE_TEXT_LAST));
            else if (kind < 65)
                t = TYPE_SEQ_SPEC;
            else
            begin
                t = 8'($urandom_range(0, 255));
                while (fixed_size(t) >= 0 || is_passed_type(t))
                    t = 8'($urandom_range(0, 255));
            end
            len = pick_length();
            send_event(t, len, $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0,
                       (t == TYPE_SEQ_SPEC && len == 0) ? 0 : len, FILL_RANDOM);
        end
        else if (kind < 85)
        begin
            // Fixed type with a wrong length, sometimes a huge one.
            t    = 8'($urandom_range(0, 1) ? TYPE_TEMPO : TYPE_CHAN_PREFIX);
            need = fixed_size(t);
            len  = $urandom_range(0, 1) ? $urandom_range(0, 9) : ($urandom & 32'h0FFF_FFFF);
            while (int'(len) == need)
                len = $urandom_range(0, 9);
            send_event(t, len, 0, 0, FILL_RANDOM);
        end
        else if (kind < 90)
        begin
            // Stream ends part way through an event.
            t   = 8'($urandom_range(0, 255));
            len = $urandom_range(0, 1) ? $urandom_range(2, 12) : ($urandom & 32'h0FFF_FFFF);
            if (len < 2)
                len = 2;
            cut = $urandom_range(0, 3);
            if (cut == 0)
                send_byte(LEAD_BYTE, 1'b0);
            else if (cut == 1)
            begin
                send_byte(LEAD_BYTE, 1'b0);
                send_byte(t, 1'b0);
            end
            else
            begin
                if (fixed_size(t) >= 0)
                    len = fixed_size(t);
                if (len > 1)
                    send_event(t, len, 0, $urandom_range(0, (len > 10) ? 9 : len - 1),
                               FILL_RANDOM);
                else
                    send_event(t, len, 0, 0, FILL_RANDOM);
            end
            send_byte(8'($urandom_range(0, 255)), 1'b1);
        end
        else if (kind < 95)
            send_overlong_length(8'($urandom_range(0, 255)));
        else
        begin
            // Noise between events, or an end of stream while idle.
            repeat ($urandom_range(1, 3))
                send_byte(8'($urandom_range(0, 254)), 1'($urandom_range(0, 3) == 0));
        end
    endtask

    // Random stream; per four segments: one full rate, one gapped, two gapped and stalled.
    task automatic test_random_stream();
        int goal;
        int segment;
        goal = bytes_sent + RANDOM_BYTES;
        segment = 0;
        while (bytes_sent < goal)
        begin
            send_gaps_on  = (segment % 4) != 1;
            out_stalls_on = (segment % 4) != 1 && (segment % 4) != 3;
            repeat (40)
                send_random_event();
            segment = segment + 1;
        end
        send_gaps_on  = 1'b1;
        out_stalls_on = 1'b1;
    endtask

    // Main sequence: reset, directed cases, random stream, then drain.
    initial
    begin
        rst_n                = 1'b0;
        s_tvalid             = 1'b0;
        s_tdata              = '0;
        s_tuser              = 1'b0;
        m_tready             = 1'b0;
        stall_left           = 0;
        cycle_count          = 0;
        mismatch_count       = 0;
        bytes_sent           = 0;
        send_gaps_on         = 1'b1;
        out_stalls_on        = 1'b1;
        shadow_phase         = PH_IDLE;
        shadow_type          = '0;
        shadow_length        = '0;
        shadow_length_bytes  = 0;
        shadow_payload_count = '0;
        shadow_value         = '0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_idle_handling();
        test_fixed_events();
        test_zero_length_payloads();
        test_length_field();
        test_early_end();
        test_random_stream();

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
